// ===== rtl/glu_pkg.sv =====
// Package for the gcd/lcm unit: sequencer states, opcode bit positions, port widths.
// No dependencies; imported by gcd_lcm_unit.
`default_nettype none

package glu_pkg;

    localparam int DATA_W   = 32;
    localparam int OPCODE_W = 2;

    // opcode bit 0 selects two's complement operands, bit 1 selects lcm
    localparam int OP_SIGNED_BIT = 0;
    localparam int OP_LCM_BIT    = 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TWOS,
        S_REDUCE,
        S_SCALE,
        S_DIV,
        S_MUL,
        S_DONE
    } glu_state_t;

endpackage

`default_nettype wire

// ===== rtl/glu_alu.sv =====
// Shared add/subtract unit of the gcd/lcm sequencer.
// Used by the reduce, divide and multiply steps; depends on nothing.
`default_nettype none

module glu_alu #(
    parameter int W = 34
) (
    input  logic [W-1:0] x,
    input  logic [W-1:0] y,
    input  logic         sub,
    output logic [W-1:0] res
);

    assign res = sub ? (x - y) : (x + y);

endmodule

`default_nettype wire

// ===== rtl/gcd_lcm_unit.sv =====
// Top level of the gcd/lcm unit: sequencer, operand registers and output register.
// Depends on glu_pkg and glu_alu.
//
//  channel  signals                              dir   beat taken when
//  -------  -----------------------------------  ----  ------------------------
//  in       in_valid, opcode, operand_a/_b       in    in_valid && !in_stall
//  out      out_valid, value, overflow           out   out_valid && !out_stall
//
// One beat at a time; the shared adder does one step per cycle.
// gcd (binary method): strips common twos, reduces by halving and subtraction, then
// rescales by shifts; lcm adds a restoring divide by the gcd and a shift-add multiply.
// Zero operands go straight to the done state. The output register frees the input side:
// a new beat is taken while a result waits; a finished result waits while out_stall.
// rst_n is asynchronous and clears the sequencer and out_valid.
`default_nettype none

module gcd_lcm_unit #(
    parameter int WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [glu_pkg::OPCODE_W-1:0]  opcode,
    input  logic [glu_pkg::DATA_W-1:0]    operand_a,
    input  logic [glu_pkg::DATA_W-1:0]    operand_b,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [glu_pkg::DATA_W-1:0]    value,
    output logic                          overflow
);

    import glu_pkg::*;

    localparam int CW = $clog2(WIDTH);
    localparam int AW = WIDTH + 2;

    glu_state_t state_reg, state_next;

    logic [WIDTH-1:0]   u_reg, u_next;
    logic [WIDTH-1:0]   v_reg, v_next;
    logic [WIDTH-1:0]   a_reg, a_next;
    logic [WIDTH-1:0]   b_reg, b_next;
    logic [CW-1:0]      k_reg, k_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               lcm_reg, lcm_next;
    logic               ovf_reg, ovf_next;
    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  value_reg, value_next;
    logic               overflow_reg, overflow_next;

    logic [WIDTH-1:0]   a_in, b_in, a_mag, b_mag;
    logic [DATA_W-1:0]  v_out;
    logic               is_signed, u_ge_v, u_eq_v;

    logic [AW-1:0]      alu_x, alu_y, alu_res;
    logic               alu_sub;

    generate
        if (WIDTH < DATA_W) begin : g_narrow
            assign a_in  = operand_a[WIDTH-1:0];
            assign b_in  = operand_b[WIDTH-1:0];
            assign v_out = {{(DATA_W-WIDTH){1'b0}}, v_reg};
        end else if (WIDTH == DATA_W) begin : g_equal
            assign a_in  = operand_a;
            assign b_in  = operand_b;
            assign v_out = v_reg;
        end else begin : g_wide
            assign a_in  = {{(WIDTH-DATA_W){1'b0}}, operand_a};
            assign b_in  = {{(WIDTH-DATA_W){1'b0}}, operand_b};
            assign v_out = v_reg[DATA_W-1:0];
        end
    endgenerate

    assign is_signed = opcode[OP_SIGNED_BIT];
    assign a_mag = (is_signed && a_in[WIDTH-1]) ? (~a_in + WIDTH'(1)) : a_in;
    assign b_mag = (is_signed && b_in[WIDTH-1]) ? (~b_in + WIDTH'(1)) : b_in;

    assign u_ge_v = (u_reg >= v_reg);
    assign u_eq_v = (u_reg == v_reg);

    glu_alu #(
        .W (AW)
    ) u_alu (
        .x   (alu_x),
        .y   (alu_y),
        .sub (alu_sub),
        .res (alu_res)
    );

    always_comb
    begin
        alu_x   = '0;
        alu_y   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            S_REDUCE:
            begin
                alu_sub = 1'b1;
                alu_x   = u_ge_v ? {2'b00, u_reg} : {2'b00, v_reg};
                alu_y   = u_ge_v ? {2'b00, v_reg} : {2'b00, u_reg};
            end
            S_DIV:
            begin
                // restoring divide step: shifted remainder minus divisor
                alu_sub = 1'b1;
                alu_x   = {1'b0, v_reg, a_reg[WIDTH-1]};
                alu_y   = {2'b00, u_reg};
            end
            S_MUL:
            begin
                // msb-first shift-add
                alu_x   = {1'b0, v_reg, 1'b0};
                alu_y   = a_reg[WIDTH-1] ? {2'b00, b_reg} : '0;
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        lcm_next       = lcm_reg;
        ovf_next       = ovf_reg;
        value_next     = value_reg;
        overflow_next  = overflow_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    u_next   = a_mag;
                    v_next   = b_mag;
                    a_next   = a_mag;
                    b_next   = b_mag;
                    k_next   = '0;
                    cnt_next = '0;
                    lcm_next = opcode[OP_LCM_BIT];
                    ovf_next = 1'b0;
                    if (a_mag == '0 || b_mag == '0)
                    begin
                        v_next     = opcode[OP_LCM_BIT] ? '0 : (a_mag | b_mag);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_TWOS;
                    end
                end
            end
            S_TWOS:
            begin
                if (u_reg[0] || v_reg[0])
                begin
                    state_next = S_REDUCE;
                end
                else
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + CW'(1);
                end
            end
            S_REDUCE:
            begin
                if (u_eq_v)
                begin
                    state_next = S_SCALE;
                end
                else if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (u_ge_v)
                begin
                    u_next = alu_res[WIDTH-1:0];
                end
                else
                begin
                    v_next = alu_res[WIDTH-1:0];
                end
            end
            S_SCALE:
            begin
                if (k_reg == '0)
                begin
                    if (lcm_reg)
                    begin
                        v_next     = '0;
                        cnt_next   = '0;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        v_next     = u_reg;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    u_next = u_reg << 1;
                    k_next = k_reg - CW'(1);
                end
            end
            S_DIV:
            begin
                a_next = {a_reg[WIDTH-2:0], !alu_res[AW-1]};
                v_next = alu_res[AW-1] ? {v_reg[WIDTH-2:0], a_reg[WIDTH-1]}
                                       : alu_res[WIDTH-1:0];
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(WIDTH - 1))
                begin
                    // gcd divides a exactly; accumulator starts at zero
                    v_next     = '0;
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                v_next   = alu_res[WIDTH-1:0];
                ovf_next = ovf_reg | (|alu_res[AW-1:WIDTH]);
                a_next   = a_reg << 1;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(WIDTH - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    value_next     = v_out;
                    overflow_next  = ovf_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg        <= u_next;
        v_reg        <= v_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        k_reg        <= k_next;
        cnt_reg      <= cnt_next;
        lcm_reg      <= lcm_next;
        ovf_reg      <= ovf_next;
        value_reg    <= value_next;
        overflow_reg <= overflow_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign overflow  = overflow_reg;

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (u_reg != '0))
        else $error("divide step with zero gcd");

    a_reduce_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REDUCE) |-> (u_reg[0] || v_reg[0]))
        else $error("reduce step with both values even");

    a_reduce_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REDUCE) |-> (u_reg != '0 && v_reg != '0))
        else $error("reduce step with a zero value");

    a_gcd_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !lcm_reg) |-> !ovf_reg)
        else $error("overflow raised on gcd");

endmodule

`default_nettype wire
